// ===== src/rmsh_pkg.sv =====
// Package for the ring median seam height block.
// Holds the word types, the height and rank types and the register indexes.
// It depends on nothing else.
package rmsh_pkg;

    localparam int NUM_NB = 8;
    localparam int HEIGHT_W = 24;
    localparam int MAX_GRID_SIDE = 4096;

    typedef logic signed [HEIGHT_W-1:0] t_height;
    typedef logic [2:0] t_rank;
    typedef logic [3:0] t_count;

    localparam logic [1:0] CFG_GRID_WIDTH = 2'd0;
    localparam logic [1:0] CFG_GRID_DEPTH = 2'd1;
    localparam logic [1:0] CFG_AGREE_TOL = 2'd2;

    typedef struct packed {
        logic [11:0] cell_x;
        logic [11:0] cell_z;
        logic [7:0]  neighbor_valid;
        t_height     height_0;
        t_height     height_1;
        t_height     height_2;
        t_height     height_3;
        t_height     height_4;
        t_height     height_5;
        t_height     height_6;
        t_height     height_7;
    } t_in_word;

    typedef struct packed {
        logic    resolved;
        t_height seam_height;
    } t_out_word;

endpackage

// ===== src/rmsh_rank_lane.sv =====
// One sort lane: finds the rank of its own height among the valid heights.
// Equal heights are ordered by neighbor position. Uses rmsh_pkg.
module rmsh_rank_lane (
    input  rmsh_pkg::t_rank   i_lane,
    input  rmsh_pkg::t_height i_self,
    input  rmsh_pkg::t_height i_heights [rmsh_pkg::NUM_NB],
    input  logic [7:0]        i_mask,
    output rmsh_pkg::t_rank   o_rank
);

    logic [3:0] cnt;

    always_comb begin
        cnt = 4'd0;
        for (int j = 0; j < rmsh_pkg::NUM_NB; j++) begin
            if (i_mask[j] && (3'(j) != i_lane) &&
                ((i_heights[j] < i_self) ||
                 ((i_heights[j] == i_self) && (3'(j) < i_lane)))) begin
                cnt = cnt + 4'd1;
            end
        end
    end

    assign o_rank = cnt[2:0];

endmodule

// ===== src/rmsh_merge.sv =====
// Merge stage: picks the middle one or two heights from the lane ranks
// and forms the median with a truncating arithmetic shift. Uses rmsh_pkg.
module rmsh_merge (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  rmsh_pkg::t_height i_heights [rmsh_pkg::NUM_NB],
    input  rmsh_pkg::t_rank   i_ranks [rmsh_pkg::NUM_NB],
    input  logic [7:0]        i_mask,
    input  rmsh_pkg::t_count  i_cnt,
    output rmsh_pkg::t_height o_median
);

    rmsh_pkg::t_count lo_rank;
    rmsh_pkg::t_count hi_rank;
    logic [7:0] sel_lo;
    logic [7:0] sel_hi;
    logic [23:0] lo_val;
    logic [23:0] hi_val;
    logic signed [24:0] sum;

    assign hi_rank = i_cnt >> 1;
    assign lo_rank = i_cnt[0] ? hi_rank : hi_rank - 4'd1;

    always_comb begin
        lo_val = '0;
        hi_val = '0;
        for (int k = 0; k < rmsh_pkg::NUM_NB; k++) begin
            sel_lo[k] = i_mask[k] && ({1'b0, i_ranks[k]} == lo_rank);
            sel_hi[k] = i_mask[k] && ({1'b0, i_ranks[k]} == hi_rank);
            lo_val = lo_val | (i_heights[k] & {24{sel_lo[k]}});
            hi_val = hi_val | (i_heights[k] & {24{sel_hi[k]}});
        end
    end

    assign sum = {lo_val[23], lo_val} + {hi_val[23], hi_val};
    assign o_median = sum[24:1];

    // Ranks of valid lanes are distinct, so each middle rank names one lane.
    a_lo_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_cnt >= 4'd5) |-> $onehot(sel_lo))
        else $error("lower middle rank not held by exactly one lane");

    a_hi_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_cnt >= 4'd5) |-> $onehot(sel_hi))
        else $error("upper middle rank not held by exactly one lane");

endmodule

// ===== src/rmsh_agree_lane.sv =====
// One consensus lane: checks whether its height lies within the tolerance
// of the median. Uses rmsh_pkg.
module rmsh_agree_lane (
    input  rmsh_pkg::t_height i_height,
    input  logic              i_valid,
    input  rmsh_pkg::t_height i_median,
    input  logic [15:0]       i_tol,
    output logic              o_near
);

    logic signed [24:0] diff;
    logic [24:0] mag;

    assign diff = {i_height[23], i_height} - {i_median[23], i_median};
    assign mag = diff[24] ? 25'(-diff) : 25'(diff);
    assign o_near = i_valid && (mag <= {9'd0, i_tol});

endmodule

// ===== src/ring_median_seam_height_top.sv =====
// Top level of the ring median seam height block.
// Instantiates the rank lanes, the merge stage and the consensus lanes; uses rmsh_pkg.
//
// The block takes one word per clock while o_in_ready is high and returns one word
// per input word, in order. It is a four-stage pipeline: eight rank lanes, the median
// merge, eight consensus lanes, then the count check into the output register; a word
// moves through the stage 1, 2 and 3 registers into the output register. A stall on
// the output backs up stage by stage, and a new word is accepted whenever the first
// stage can move. The user must write configuration through i_cfg_wr_en, i_cfg_idx
// and i_cfg_data only while idle; the block itself does not enforce this.
module ring_median_seam_height_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_idx,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rmsh_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rmsh_pkg::t_out_word o_out_word
);

    logic [12:0] r_grid_width;
    logic [12:0] r_grid_depth;
    logic [15:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= 13'd256;
            r_grid_depth <= 13'd256;
            r_tol <= 16'd128;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                rmsh_pkg::CFG_GRID_WIDTH: r_grid_width <= i_cfg_data[12:0];
                rmsh_pkg::CFG_GRID_DEPTH: r_grid_depth <= i_cfg_data[12:0];
                rmsh_pkg::CFG_AGREE_TOL:  r_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic adv1;
    logic adv2;
    logic adv3;
    logic adv4;
    logic r_s1_v;
    logic r_s2_v;
    logic r_s3_v;
    logic r_out_v;

    assign adv4 = !r_out_v || i_out_ready;
    assign adv3 = !r_s3_v || adv4;
    assign adv2 = !r_s2_v || adv3;
    assign adv1 = !r_s1_v || adv2;
    assign o_in_ready = adv1;
    assign o_out_valid = r_out_v;

    // Input unpacking and border test.
    rmsh_pkg::t_height in_h [rmsh_pkg::NUM_NB];
    logic [12:0] w_eff;
    logic [12:0] d_eff;
    logic border;
    rmsh_pkg::t_rank ranks [rmsh_pkg::NUM_NB];

    assign in_h[0] = i_in_word.height_0;
    assign in_h[1] = i_in_word.height_1;
    assign in_h[2] = i_in_word.height_2;
    assign in_h[3] = i_in_word.height_3;
    assign in_h[4] = i_in_word.height_4;
    assign in_h[5] = i_in_word.height_5;
    assign in_h[6] = i_in_word.height_6;
    assign in_h[7] = i_in_word.height_7;

    assign w_eff = (r_grid_width > 13'(rmsh_pkg::MAX_GRID_SIDE)) ?
                   13'(rmsh_pkg::MAX_GRID_SIDE) : r_grid_width;
    assign d_eff = (r_grid_depth > 13'(rmsh_pkg::MAX_GRID_SIDE)) ?
                   13'(rmsh_pkg::MAX_GRID_SIDE) : r_grid_depth;
    assign border = (i_in_word.cell_x == 12'd0) || (i_in_word.cell_z == 12'd0) ||
                    (({2'b0, i_in_word.cell_x} + 14'd1) >= {1'b0, w_eff}) ||
                    (({2'b0, i_in_word.cell_z} + 14'd1) >= {1'b0, d_eff});

    for (genvar g = 0; g < rmsh_pkg::NUM_NB; g++) begin : g_rank
        rmsh_rank_lane u_rank (
            .i_lane    (3'(g)),
            .i_self    (in_h[g]),
            .i_heights (in_h),
            .i_mask    (i_in_word.neighbor_valid),
            .o_rank    (ranks[g])
        );
    end

    // Stage 1 registers.
    rmsh_pkg::t_height r_s1_h [rmsh_pkg::NUM_NB];
    rmsh_pkg::t_rank   r_s1_rank [rmsh_pkg::NUM_NB];
    logic [7:0]        r_s1_mask;
    rmsh_pkg::t_count  r_s1_cnt;
    logic              r_s1_border;

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_h <= in_h;
            r_s1_rank <= ranks;
            r_s1_mask <= i_in_word.neighbor_valid;
            r_s1_cnt <= 4'($countones(i_in_word.neighbor_valid));
            r_s1_border <= border;
        end
    end

    rmsh_pkg::t_height median;

    rmsh_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_v),
        .i_heights (r_s1_h),
        .i_ranks   (r_s1_rank),
        .i_mask    (r_s1_mask),
        .i_cnt     (r_s1_cnt),
        .o_median  (median)
    );

    // Stage 2 registers.
    rmsh_pkg::t_height r_s2_h [rmsh_pkg::NUM_NB];
    logic [7:0]        r_s2_mask;
    rmsh_pkg::t_count  r_s2_cnt;
    logic              r_s2_reject;
    rmsh_pkg::t_height r_s2_median;

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_s2_h <= r_s1_h;
            r_s2_mask <= r_s1_mask;
            r_s2_cnt <= r_s1_cnt;
            r_s2_reject <= r_s1_border || (r_s1_cnt < 4'd5);
            r_s2_median <= median;
        end
    end

    logic [7:0] near;

    for (genvar g = 0; g < rmsh_pkg::NUM_NB; g++) begin : g_agree
        rmsh_agree_lane u_agree (
            .i_height (r_s2_h[g]),
            .i_valid  (r_s2_mask[g]),
            .i_median (r_s2_median),
            .i_tol    (r_tol),
            .o_near   (near[g])
        );
    end

    // Stage 3 registers.
    logic [7:0]        r_s3_near;
    rmsh_pkg::t_count  r_s3_cnt;
    logic              r_s3_reject;
    rmsh_pkg::t_height r_s3_median;

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_s3_near <= near;
            r_s3_cnt <= r_s2_cnt;
            r_s3_reject <= r_s2_reject;
            r_s3_median <= r_s2_median;
        end
    end

    logic [5:0] thr_sum;
    rmsh_pkg::t_count thr;
    rmsh_pkg::t_count near_cnt;
    rmsh_pkg::t_out_word n_out_word;
    rmsh_pkg::t_out_word r_out_word;

    assign thr_sum = ({2'b0, r_s3_cnt} << 1) + {2'b0, r_s3_cnt} + 6'd3;
    assign thr = thr_sum[5:2];
    assign near_cnt = 4'($countones(r_s3_near));

    always_comb begin
        n_out_word.resolved = !r_s3_reject && (near_cnt >= thr);
        n_out_word.seam_height = n_out_word.resolved ? r_s3_median : '0;
    end

    always_ff @(posedge i_clk) begin
        if (adv4) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_word = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_v <= i_in_valid;
            end
            if (adv2) begin
                r_s2_v <= r_s1_v;
            end
            if (adv3) begin
                r_s3_v <= r_s2_v;
            end
            if (adv4) begin
                r_out_v <= r_s3_v;
            end
        end
    end

    a_zero_when_unresolved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_word.resolved) |-> (r_out_word.seam_height == '0))
        else $error("unresolved word carries a nonzero height");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_v |-> o_in_ready)
        else $error("input stalled while the output register is empty");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_v)
        else $error("output word valid right after reset");

endmodule
